[design/rd32_pkg.sv]
// ----------------------------------------------------------------------------
// rd32_pkg
// Shared operation codes and the control word that travels with each
// division along the cell chain.
// ----------------------------------------------------------------------------
package rd32_pkg;

  localparam logic [1:0] KIND_UDIV = 2'd0;
  localparam logic [1:0] KIND_UREM = 2'd1;
  localparam logic [1:0] KIND_SDIV = 2'd2;
  localparam logic [1:0] KIND_SREM = 2'd3;

  // widest result the block ever reports
  localparam int unsigned RESULT_BITS_MAX = 32;

  typedef struct packed {
    logic valid;
    logic is_rem;
    logic neg_res;
  } ctl_t;

endpackage

[design/rd32_cell.sv]
// ----------------------------------------------------------------------------
// rd32_cell
// One restoring division step: shifts the next dividend bit into the
// partial remainder, makes the trial subtraction and shifts the quotient
// bit into the low end of the dividend/quotient word.
// ----------------------------------------------------------------------------
module rd32_cell #(
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rd32_pkg::ctl_t     in_ctl,
  input  logic [WIDTH-1:0]   in_rem,
  input  logic [WIDTH-1:0]   in_nq,
  input  logic [WIDTH-1:0]   in_div,
  output rd32_pkg::ctl_t     out_ctl,
  output logic [WIDTH-1:0]   out_rem,
  output logic [WIDTH-1:0]   out_nq,
  output logic [WIDTH-1:0]   out_div
);

  import rd32_pkg::*;

  ctl_t             ctl_r;
  logic [WIDTH-1:0] rem_r;
  logic [WIDTH-1:0] nq_r;
  logic [WIDTH-1:0] div_r;

  logic [WIDTH:0]   trial;
  logic [WIDTH+1:0] diff;
  logic             take;
  logic [WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0] nq_nxt;

  always_comb begin
    trial   = {in_rem, in_nq[WIDTH-1]};
    diff    = {1'b0, trial} - {2'b00, in_div};
    take    = ~diff[WIDTH+1];
    rem_nxt = take ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    nq_nxt  = {in_nq[WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    div_r <= in_div;
  end

  assign out_ctl = ctl_r;
  assign out_rem = rem_r;
  assign out_nq  = nq_r;
  assign out_div = div_r;

endmodule

[design/rd32_post.sv]
// ----------------------------------------------------------------------------
// rd32_post
// Picks quotient or remainder, reapplies the sign and registers the
// result word with its strobe.
// ----------------------------------------------------------------------------
module rd32_post #(
  parameter int unsigned WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rd32_pkg::ctl_t     in_ctl,
  input  logic [WIDTH-1:0]   in_rem,
  input  logic [WIDTH-1:0]   in_quo,
  output logic               out_valid,
  output logic [WIDTH-1:0]   out_result
);

  import rd32_pkg::*;

  logic             valid_r;
  logic [WIDTH-1:0] result_r;
  logic [WIDTH-1:0] sel;
  logic [WIDTH-1:0] signed_res;
  logic [WIDTH-1:0] res_mask;
  logic [WIDTH-1:0] result_nxt;

  // results are reported on at most the low 32 bits
  for (genvar i = 0; i < WIDTH; i++) begin : g_mask
    assign res_mask[i] = (i < RESULT_BITS_MAX);
  end

  always_comb begin
    sel        = in_ctl.is_rem ? in_rem : in_quo;
    signed_res = in_ctl.neg_res ? ('0 - sel) : sel;
    result_nxt = signed_res & res_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

[design/restoring_divider_32_unit.sv]
// ----------------------------------------------------------------------------
// restoring_divider_32_unit
// Pipelined restoring divider, unsigned and signed, quotient or remainder.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken on every clock edge with start high and busy low; busy
//   never rises, so a new division may be issued in every cycle.
//   in_kind selects unsigned quotient, unsigned remainder, signed quotient
//   (truncated toward zero) or signed remainder (sign of the dividend).
//   The front stage takes magnitudes, a row of DATA_WIDTH identical cells
//   resolves one quotient bit each, and the back stage restores the sign.
//   Each word passes the front-stage register, the cell registers and the
//   back-stage register; the result appears on out_result with out_valid
//   high for one cycle. Throughput is one division per cycle, set by the
//   one-bit-per-cell row.
//   Division by zero gives all ones for the unsigned quotient, the dividend
//   for either remainder, and all ones or 1 for the signed quotient.
//   There is no stall input: the receiver must take every result word.
//   Synchronous reset drops every division in flight; no word is produced
//   for them.
// ----------------------------------------------------------------------------
module restoring_divider_32_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_kind,
  input  logic [DATA_WIDTH-1:0] in_dividend,
  input  logic [DATA_WIDTH-1:0] in_divisor,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_result
);

  import rd32_pkg::*;

  localparam int unsigned W = DATA_WIDTH;

  ctl_t         ctl_c [0:W];
  logic [W-1:0] rem_c [0:W];
  logic [W-1:0] nq_c  [0:W];
  logic [W-1:0] div_c [0:W];

  ctl_t         ctl_nxt;
  logic         sign_a;
  logic         sign_b;
  logic         is_signed;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;

  ctl_t         ctl_r;
  logic [W-1:0] nq_r;
  logic [W-1:0] div_r;

  // front stage: magnitudes and sign plan
  always_comb begin
    sign_a  = in_dividend[W-1];
    sign_b  = in_divisor[W-1];
    ctl_nxt = '0;
    ctl_nxt.valid = start;
    is_signed = 1'b0;
    unique case (in_kind)
      KIND_UDIV: begin
        ctl_nxt.is_rem = 1'b0;
      end
      KIND_UREM: begin
        ctl_nxt.is_rem = 1'b1;
      end
      KIND_SDIV: begin
        is_signed       = 1'b1;
        ctl_nxt.is_rem  = 1'b0;
        ctl_nxt.neg_res = sign_a ^ sign_b;
      end
      KIND_SREM: begin
        is_signed       = 1'b1;
        ctl_nxt.is_rem  = 1'b1;
        ctl_nxt.neg_res = sign_a;
      end
      default: begin
        ctl_nxt.is_rem = 1'b0;
      end
    endcase
    mag_a = (is_signed && sign_a) ? ('0 - in_dividend) : in_dividend;
    mag_b = (is_signed && sign_b) ? ('0 - in_divisor) : in_divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r  <= mag_a;
    div_r <= mag_b;
  end

  assign busy = 1'b0;

  assign ctl_c[0] = ctl_r;
  assign rem_c[0] = '0;
  assign nq_c[0]  = nq_r;
  assign div_c[0] = div_r;

  for (genvar i = 0; i < W; i++) begin : g_cell
    rd32_cell #(
      .WIDTH (W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (ctl_c[i]),
      .in_rem  (rem_c[i]),
      .in_nq   (nq_c[i]),
      .in_div  (div_c[i]),
      .out_ctl (ctl_c[i+1]),
      .out_rem (rem_c[i+1]),
      .out_nq  (nq_c[i+1]),
      .out_div (div_c[i+1])
    );
  end

  rd32_post #(
    .WIDTH (W)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ctl     (ctl_c[W]),
    .in_rem     (rem_c[W]),
    .in_quo     (nq_c[W]),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule

[design/rd32_chk.sv]
// ----------------------------------------------------------------------------
// rd32_chk
// Port-level checks on the divider: fixed latency and the divide-by-zero
// results of the unsigned quotient and both remainders, bound onto the top level.
// ----------------------------------------------------------------------------
module rd32_chk #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [1:0]            in_kind,
  input logic [DATA_WIDTH-1:0] in_dividend,
  input logic [DATA_WIDTH-1:0] in_divisor,
  input logic                  out_valid,
  input logic [DATA_WIDTH-1:0] out_result
);

  import rd32_pkg::*;

  localparam int unsigned LAT = DATA_WIDTH + 2;
  localparam int unsigned RB  =
    (DATA_WIDTH < RESULT_BITS_MAX) ? DATA_WIDTH : RESULT_BITS_MAX;

  logic acc;
  assign acc = start && !busy;

  // every accepted word comes back after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("accepted word produced no result");

  // no result word without a matching acceptance
  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAT))
    else $error("result word without an accepted word");

  a_udiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_kind == KIND_UDIV && in_divisor == '0)
      |-> ##LAT (out_result[RB-1:0] == {RB{1'b1}}))
    else $error("unsigned quotient by zero is not all ones");

  a_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_kind == KIND_UREM || in_kind == KIND_SREM) && in_divisor == '0)
      |-> ##LAT (out_result[RB-1:0] == $past(in_dividend[RB-1:0], LAT)))
    else $error("remainder by zero is not the dividend");

endmodule

bind restoring_divider_32_unit rd32_chk #(.DATA_WIDTH(DATA_WIDTH)) u_rd32_chk (.*);

[dv/restoring_divider_32_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// restoring_divider_32_unit_tb
// Self-checking bench for the pipelined divider. A queue of division words
// is driven with random gaps in several phases. Every accepted word gets an
// expected quotient or remainder from a local model, and each result word
// is checked in order against it.
// ----------------------------------------------------------------------------
module restoring_divider_32_unit_tb;
  import rd32_pkg::*;

  localparam int unsigned W         = RESULT_BITS_MAX;
  localparam int unsigned WAIT_MAX  = 2000;
  localparam int unsigned DRAIN_CYC = W + 8;
  localparam int unsigned N_RANDOM  = 1280;
  localparam int unsigned N_PHASES  = 8;

  typedef struct {
    logic [1:0]   kind;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    int unsigned  gap_pct;
    bit           drain;
  } div_req_t;

  typedef struct {
    logic [1:0]   kind;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic [W-1:0] result;
  } div_expect_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [1:0]   in_kind = KIND_UDIV;
  logic [W-1:0] in_dividend = '0;
  logic [W-1:0] in_divisor = '0;
  logic         out_valid;
  logic [W-1:0] out_result;

  div_req_t    div_queue[$];
  div_expect_t result_expected[$];
  div_req_t    next_req;
  div_expect_t got_exp;
  bit          word_taken = 1'b0;
  int unsigned n_taken = 0;
  int unsigned n_items = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;

  restoring_divider_32_unit #(.DATA_WIDTH(W)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_kind    (in_kind),
    .in_dividend(in_dividend),
    .in_divisor (in_divisor),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always #6 clk = ~clk;

  function automatic logic [W-1:0] divide_word(logic [1:0] kind, logic [W-1:0] a,
                                               logic [W-1:0] b);
    logic [W-1:0] mag_a;
    logic [W-1:0] mag_b;
    logic [W-1:0] part;
    logic [W-1:0] res;
    mag_a = a[W-1] ? -a : a;
    mag_b = b[W-1] ? -b : b;
    case (kind)
      KIND_UDIV: res = (b == '0) ? '1 : a / b;
      KIND_UREM: res = (b == '0) ? a : a % b;
      KIND_SDIV: begin
        part = (mag_b == '0) ? '1 : mag_a / mag_b;
        res  = (a[W-1] ^ b[W-1]) ? -part : part;
      end
      default: begin
        part = (mag_b == '0) ? mag_a : mag_a % mag_b;
        res  = a[W-1] ? -part : part;
      end
    endcase
    return res;
  endfunction

  function automatic logic [W-1:0] pick_operand(bit is_divisor);
    logic [W-1:0] corner_vals[8];
    logic [W-1:0] v;
    corner_vals = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h7fff_ffff,
                    32'h8000_0000, 32'h8000_0001, 32'hffff_fffe, 32'hffff_ffff};
    case ($urandom_range(9))
      0: v = corner_vals[$urandom_range(7)];
      1: v = $urandom_range(15);
      2: v = -$urandom_range(1, 15);
      3: v = $urandom >> $urandom_range(W - 1);
      4: v = -($urandom >> $urandom_range(W - 1));
      default: v = $urandom;
    endcase
    if (is_divisor && $urandom_range(99) < 3)
      v = '0;
    return v;
  endfunction

  function automatic div_req_t make_req(logic [1:0] kind, logic [W-1:0] a,
                                        logic [W-1:0] b, int unsigned gap_pct,
                                        bit drain);
    div_req_t r;
    r.kind     = kind;
    r.dividend = a;
    r.divisor  = b;
    r.gap_pct  = gap_pct;
    r.drain    = drain;
    return r;
  endfunction

  // directed words first, then random phases with varying sender gaps
  initial begin
    logic [W-1:0] dir_a[6];
    logic [W-1:0] dir_b[6];
    int unsigned  phase_gap[4];
    int unsigned  gap;
    dir_a = '{32'h8000_0000, 32'hffff_ffff, 32'h0000_0064, 32'h7fff_ffff,
              32'h0000_0000, 32'hffff_fff9};
    dir_b = '{32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
              32'h8000_0000, 32'h0000_0002};
    phase_gap = '{0, 58, 0, 7};
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 6; j++)
        div_queue.push_back(make_req(k[1:0], dir_a[j], dir_b[j], 0, 1'b0));
    for (int p = 0; p < N_PHASES; p++) begin
      gap = phase_gap[p % 4];
      for (int j = 0; j < N_RANDOM / N_PHASES; j++)
        div_queue.push_back(make_req(2'($urandom_range(3)), pick_operand(1'b0),
                                     pick_operand(1'b1), gap,
                                     j == 0 || j == N_RANDOM / (2 * N_PHASES)));
    end
    n_items = div_queue.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_taken != n_items || result_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || word_taken) begin
      if (div_queue.size() == 0) begin
        start <= 1'b0;
      end else if (div_queue[0].drain && result_expected.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(99) < div_queue[0].gap_pct) begin
        start <= 1'b0;
      end else begin
        next_req = div_queue.pop_front();
        start       <= 1'b1;
        in_kind     <= next_req.kind;
        in_dividend <= next_req.dividend;
        in_divisor  <= next_req.divisor;
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    word_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (result_expected.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result word %h", out_result);
        end else begin
          got_exp = result_expected.pop_front();
          if (out_result !== got_exp.result) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch kind %0d a %h b %h: expected %h got %h",
                       got_exp.kind, got_exp.dividend, got_exp.divisor,
                       got_exp.result, out_result);
          end
        end
      end
      if (start && !busy) begin
        result_expected.push_back('{in_kind, in_dividend, in_divisor,
                                    divide_word(in_kind, in_dividend, in_divisor)});
        n_taken++;
      end
      if ((start && !busy) || out_valid) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WAIT_MAX) begin
          $display("timeout waiting for the divider");
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

endmodule
